/* hw/rtl/bra_pkg.sv */
// Shared types and constants for the bitmap range allocator.
// Used by bra_ctrl, bra_datapath and bitmap_range_allocator; no dependencies.
package bra_pkg;

    // Occupancy map word: sixteen slots per memory row
    localparam int WORD_BITS = 16;
    localparam int WORD_LOG  = 4;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 24;    // count(9) + start_req(8), padded to bytes
    localparam int OUT_DATA_W = 136;   // first_slot(8) + host(64) + device(64)

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NORUN   = 2'd1;
    localparam logic [1:0] ST_BADFREE = 2'd2;

    // Request op codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        PASS_SCAN  = 2'd0,   // search for first free run
        PASS_CHECK = 2'd1,   // verify run is fully used before freeing
        PASS_SET   = 2'd2,   // mark run used
        PASS_CLR   = 2'd3    // mark run free
    } t_pass;

    typedef struct packed {
        logic       load;        // latch request fields
        logic       go;          // arm a sweep over the words of a range
        t_pass      kind;
        logic       sweep;       // step the sweep one word
        logic       mul;         // form first slot times stride
        logic       res_load;    // load the output register
        logic [1:0] res_status;
        logic       res_addr;    // result carries index and addresses
    } t_dp_cmd;

    typedef struct packed {
        logic bad_count;   // zero count, or allocate larger than active size
        logic bad_range;   // free run leaves the active size
        logic is_free;
        logic hit;         // scan found a run in the current word
        logic miss;        // check found a free slot inside the run
        logic done;        // last word of the range processed this cycle
    } t_dp_stat;

endpackage

/* hw/rtl/bra_datapath.sv */
// Datapath of the bitmap range allocator: config registers, occupancy map
// memory with per-row valid bits, word sweep, run search and address math.
// Depends on bra_pkg.
module bra_datapath #(
    parameter int SLOTS = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bra_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_op,
    input  logic [8:0]                    i_in_count,
    input  logic [7:0]                    i_in_start,
    input  bra_pkg::t_dp_cmd              i_cmd,
    output bra_pkg::t_dp_stat             o_stat,
    output logic [1:0]                    o_status,
    output logic [7:0]                    o_first_slot,
    output logic [63:0]                   o_host_address,
    output logic [63:0]                   o_device_address
);
    import bra_pkg::*;

    localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int GW     = AW + WORD_LOG;
    localparam int LW     = ((GW > 9) ? GW : 9) + 1;
    localparam int PW     = LW + 16;
    localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

    // configuration
    logic [8:0]  r_active;
    logic [15:0] r_stride;
    logic [63:0] r_host;
    logic [63:0] r_dev;

    // request
    logic       r_op;
    logic [8:0] r_count;
    logic [7:0] r_start;

    // sweep
    t_pass          r_kind;
    logic [LW-1:0]  r_lo, r_hi;
    logic [AW-1:0]  r_addr, r_last, r_dat_addr;
    logic           r_rd_on, r_dat_v;
    logic [WORD_BITS-1:0] r_rdata;
    logic           r_rvalid;
    logic [NWORDS-1:0] r_wvalid;
    logic [LW-1:0]  r_run, r_first;
    logic [PW-1:0]  r_prod;

    logic [WORD_BITS-1:0] mem [0:NWORDS-1];

    // outputs
    logic [1:0]  r_o_status;
    logic [7:0]  r_o_first;
    logic [63:0] r_o_host, r_o_dev;

    logic [LW-1:0] lim, cnt, stl, lo, hi, hm1;
    logic [WORD_BITS-1:0] dat, inr, wr_data;
    logic          proc, rd, wr_en;
    logic          scan_hit;
    logic [LW-1:0] scan_s, run_end;

    assign cnt = LW'(r_count);
    assign stl = LW'(r_start);
    assign lim = (LW'(r_active) > SLOTS_L) ? SLOTS_L : LW'(r_active);

    assign o_stat.bad_count = (r_count == '0) || ((r_op == OP_ALLOC) && (cnt > lim));
    assign o_stat.bad_range = (r_op == OP_FREE) && ((stl >= lim) || (cnt > lim - stl));
    assign o_stat.is_free   = (r_op == OP_FREE);

    always_comb begin
        unique case (i_cmd.kind)
            PASS_SCAN: begin
                lo = '0;
                hi = lim;
            end
            PASS_SET: begin
                lo = r_first;
                hi = r_first + cnt;
            end
            PASS_CHECK, PASS_CLR: begin
                lo = stl;
                hi = stl + cnt;
            end
            default: begin
                lo = '0;
                hi = lim;
            end
        endcase
        hm1 = hi - LW'(1);
    end

    assign dat = r_rvalid ? r_rdata : '0;

    // in-range mask of the word under processing
    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            inr[j] = (((LW'(r_dat_addr) << WORD_LOG) + LW'(j)) >= r_lo) &&
                     (((LW'(r_dat_addr) << WORD_LOG) + LW'(j)) <  r_hi);
        end
    end

    // Free run ending at each bit: trailing free bits within the word, plus the
    // carried-in run when the whole prefix is free. Lowest qualifying bit wins.
    always_comb begin : p_scan
        logic [WORD_BITS-1:0] fr;
        logic [WORD_LOG:0]    lastu;
        logic [LW-1:0]        runj;
        fr       = inr & ~dat;
        scan_hit = 1'b0;
        scan_s   = '0;
        run_end  = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            lastu = '0;
            for (int k = 0; k <= j; k++) begin
                if (!fr[k]) lastu = (WORD_LOG+1)'(k + 1);
            end
            if (lastu == '0) runj = r_run + LW'(j + 1);
            else             runj = LW'(j + 1) - LW'(lastu);
            if (!scan_hit && (runj >= cnt)) begin
                scan_hit = 1'b1;
                scan_s   = (LW'(r_dat_addr) << WORD_LOG) + LW'(j + 1) - cnt;
            end
            if (j == WORD_BITS - 1) run_end = runj;
        end
    end

    assign proc    = i_cmd.sweep && r_dat_v;
    assign rd      = i_cmd.sweep && r_rd_on;
    assign wr_en   = proc && ((r_kind == PASS_SET) || (r_kind == PASS_CLR));
    assign wr_data = (r_kind == PASS_SET) ? (dat | inr) : (dat & ~inr);

    assign o_stat.hit  = proc && (r_kind == PASS_SCAN) && scan_hit;
    assign o_stat.miss = proc && (r_kind == PASS_CHECK) && (|(inr & ~dat));
    assign o_stat.done = proc && (r_dat_addr == r_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 9'd256;
            r_stride <= 16'd32;
            r_host   <= '0;
            r_dev    <= '0;
            r_rd_on  <= 1'b0;
            r_dat_v  <= 1'b0;
            r_wvalid <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ACTIVE: r_active <= i_cfg_data[8:0];
                    CFG_STRIDE: r_stride <= i_cfg_data[15:0];
                    CFG_HOST:   r_host   <= i_cfg_data;
                    CFG_DEVICE: r_dev    <= i_cfg_data;
                    default:    r_host   <= r_host;
                endcase
            end
            if (i_cmd.go) begin
                r_rd_on <= 1'b1;
            end else if (rd && (r_addr == r_last)) begin
                r_rd_on <= 1'b0;
            end
            r_dat_v <= rd;
            if (wr_en) r_wvalid[r_dat_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_op;
            r_count <= i_in_count;
            r_start <= i_in_start;
        end
        if (i_cmd.go) begin
            r_kind <= i_cmd.kind;
            r_lo   <= lo;
            r_hi   <= hi;
            r_addr <= lo[AW+WORD_LOG-1:WORD_LOG];
            r_last <= hm1[AW+WORD_LOG-1:WORD_LOG];
            r_run  <= '0;
        end else if (rd) begin
            r_addr <= r_addr + AW'(1);
        end
        if (rd) begin
            r_dat_addr <= r_addr;
            r_rvalid   <= r_wvalid[r_addr];
        end
        if (proc && (r_kind == PASS_SCAN)) begin
            if (scan_hit) r_first <= scan_s;
            else          r_run   <= run_end;
        end
        if (i_cmd.mul) r_prod <= PW'(r_first) * PW'(r_stride);
        if (i_cmd.res_load) begin
            r_o_status <= i_cmd.res_status;
            if (i_cmd.res_addr) begin
                r_o_first <= r_first[7:0];
                r_o_host  <= r_host + 64'(r_prod);
                r_o_dev   <= r_dev + 64'(r_prod);
            end else begin
                r_o_first <= '0;
                r_o_host  <= '0;
                r_o_dev   <= '0;
            end
        end
    end

    // occupancy map: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (rd)    r_rdata <= mem[r_addr];
        if (wr_en) mem[r_dat_addr] <= wr_data;
    end

    assign o_status         = r_o_status;
    assign o_first_slot     = r_o_first;
    assign o_host_address   = r_o_host;
    assign o_device_address = r_o_dev;

endmodule

/* hw/rtl/bra_ctrl.sv */
// Controller of the bitmap range allocator: request sequencing state machine
// and output register handshake. Depends on bra_pkg.
module bra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bra_pkg::t_dp_stat i_stat,
    output bra_pkg::t_dp_cmd  o_cmd
);
    import bra_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CHK   = 10'b00_0000_0010,
        S_SCAN  = 10'b00_0000_0100,
        S_CHECK = 10'b00_0000_1000,
        S_PSET  = 10'b00_0001_0000,
        S_SETW  = 10'b00_0010_0000,
        S_PCLR  = 10'b00_0100_0000,
        S_CLRW  = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_RES   = 10'b10_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_status, n_status;
    logic       r_addr_en, n_addr_en;

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_addr_en   = r_addr_en;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.kind  = PASS_SCAN;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                n_addr_en = 1'b0;
                if (i_stat.bad_count) begin
                    n_status = ST_NORUN;
                    n_state  = S_RES;
                end else if (i_stat.bad_range) begin
                    n_status = ST_BADFREE;
                    n_state  = S_RES;
                end else begin
                    o_cmd.go   = 1'b1;
                    o_cmd.kind = i_stat.is_free ? PASS_CHECK : PASS_SCAN;
                    n_state    = i_stat.is_free ? S_CHECK : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.sweep = 1'b1;
                o_cmd.kind  = PASS_SCAN;
                if (i_stat.hit) begin
                    n_state = S_PSET;
                end else if (i_stat.done) begin
                    n_status = ST_NORUN;
                    n_state  = S_RES;
                end
            end
            S_CHECK: begin
                o_cmd.sweep = 1'b1;
                o_cmd.kind  = PASS_CHECK;
                if (i_stat.miss) begin
                    n_status = ST_BADFREE;
                    n_state  = S_RES;
                end else if (i_stat.done) begin
                    n_state = S_PCLR;
                end
            end
            S_PSET: begin
                o_cmd.go   = 1'b1;
                o_cmd.kind = PASS_SET;
                n_state    = S_SETW;
            end
            S_SETW: begin
                o_cmd.sweep = 1'b1;
                o_cmd.kind  = PASS_SET;
                if (i_stat.done) n_state = S_MUL;
            end
            S_PCLR: begin
                o_cmd.go   = 1'b1;
                o_cmd.kind = PASS_CLR;
                n_state    = S_CLRW;
            end
            S_CLRW: begin
                o_cmd.sweep = 1'b1;
                o_cmd.kind  = PASS_CLR;
                if (i_stat.done) begin
                    n_status = ST_OK;
                    n_state  = S_RES;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_status  = ST_OK;
                n_addr_en = 1'b1;
                n_state   = S_RES;
            end
            S_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_status;
                    o_cmd.res_addr   = r_addr_en;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_addr_en <= n_addr_en;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_hit_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_stat.hit) |=> (r_state == S_PSET))
        else $error("scan hit did not start the mark pass");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before it was taken");

    a_load_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_CHK))
        else $error("accepted request skipped the precheck");

    a_alloc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |=> (r_state == S_RES && r_addr_en && r_status == ST_OK))
        else $error("allocation result not marked ok with addresses");
`endif

endmodule

/* hw/rtl/bitmap_range_allocator.sv */
// Top level of the bitmap range allocator: first-fit contiguous slot
// allocation over an occupancy map. Depends on bra_pkg, bra_ctrl, bra_datapath.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tuser op, tdata count, start_req
//  m_axis    out        m_axis_tvalid/m_axis_tready   tuser status, tdata slot, addresses
//  cfg       in         i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// Map memory is read one 16-slot word per cycle during a sweep. After a precheck,
// an allocate scans for the first free run (Ws words), marks it used (Wm words)
// and forms the addresses; a free checks the run (W words) and clears it; a rejected
// request goes straight to the result. The controller then returns to idle.
// Reset is synchronous; the map reads as all free after reset through per-row
// valid bits, no clearing pass. Input is taken only between requests; a result
// waiting in the output register does not block the next request's work.
module bitmap_range_allocator #(
    parameter int SLOTS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bra_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // count[8:0], start_req[16:9]
    input  logic                              s_axis_tuser,  // op[0]
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bra_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // first_slot[7:0], host_address[71:8],
                                                             // device_address[135:72]
    output logic [1:0]                        m_axis_tuser,  // status[1:0]
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bra_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bra_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bra_pkg::*;

    t_dp_cmd     cmd;
    t_dp_stat    stat;
    logic [1:0]  status;
    logic [7:0]  first_slot;
    logic [63:0] host_address, device_address;

    bra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bra_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_op          (s_axis_tuser),
        .i_in_count       (s_axis_tdata[8:0]),
        .i_in_start       (s_axis_tdata[16:9]),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_status         (status),
        .o_first_slot     (first_slot),
        .o_host_address   (host_address),
        .o_device_address (device_address)
    );

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {device_address, host_address, first_slot};
    assign m_axis_tuser = status;

endmodule
